// ===== hdl/sobel_edge_magnitude_rgb_top_defines.svh =====
// assertion helpers for the sobel edge top file
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_TOP_DEFINES_SVH

// condition holds at every edge outside reset
`define SOBM_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SOBM_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SOBM_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sobm_pkg.sv =====
package sobm_pkg;

  // field and register widths
  localparam int PIX_BITS      = 24;
  localparam int STORE_BITS    = 2 * PIX_BITS;
  localparam int WIDTH_BITS    = 12;
  localparam int HEIGHT_BITS   = 13;
  localparam int CFG_DATA_BITS = 13;

  // register limits and reset values
  localparam int WIDTH_MIN    = 3;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_MIN   = 1;
  localparam int HEIGHT_MAX   = 4096;
  localparam int HEIGHT_RESET = 480;

  // magnitude saturation
  localparam logic [7:0] MAG_MAX = 8'd255;

  // register indexes
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // one input beat
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       flush_item;
  } pix_beat_t;

  // one result beat
  typedef struct packed {
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       frame_end;
  } mag_beat_t;

  // per-item control worked out at accept time
  typedef struct packed {
    logic c_zero;
    logic res_valid;
    logic top_m;
    logic bot_m;
    logic left_m;
    logic right_m;
    logic frame_end;
    logic restart;
  } item_ctl_t;

  // one channel of the 3x3 window, index col*3+row
  typedef logic [8:0][7:0] chan_win_t;

endpackage

// ===== hdl/sobm_line_store.sv =====
module sobm_line_store #(
  parameter int DEPTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr,
  output logic [sobm_pkg::STORE_BITS-1:0]      rd_data,
  input  logic                                 wr_en,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr,
  input  logic [sobm_pkg::STORE_BITS-1:0]      wr_data
);
  import sobm_pkg::*;

  logic [STORE_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sobm_channel_edge.sv =====
module sobm_channel_edge (
  input  sobm_pkg::chan_win_t win,
  output logic [7:0]          mag
);
  import sobm_pkg::*;

  logic [9:0]  gxp, gxn, gyp, gyn;
  logic [9:0]  ax, ay;
  logic [10:0] sum;
  logic [9:0]  half;

  // column and row weighted sums
  assign gxp = {2'b0, win[6]} + {1'b0, win[7], 1'b0} + {2'b0, win[8]};
  assign gxn = {2'b0, win[0]} + {1'b0, win[1], 1'b0} + {2'b0, win[2]};
  assign gyp = {2'b0, win[2]} + {1'b0, win[5], 1'b0} + {2'b0, win[8]};
  assign gyn = {2'b0, win[0]} + {1'b0, win[3], 1'b0} + {2'b0, win[6]};

  // absolute gradients
  assign ax = (gxp >= gxn) ? (gxp - gxn) : (gxn - gxp);
  assign ay = (gyp >= gyn) ? (gyp - gyn) : (gyn - gyp);

  // halve and saturate
  assign sum  = {1'b0, ax} + {1'b0, ay};
  assign half = sum[10:1];
  assign mag  = (half > {2'b0, MAG_MAX}) ? MAG_MAX : half[7:0];

endmodule

// ===== hdl/sobel_edge_magnitude_rgb_top.sv =====
// channel  dir  beat         handshake
// pix      in   pix_beat_t   pix_valid / pix_stall
// mag      out  mag_beat_t   mag_valid / mag_stall
// cfg      in   width, height  cfg_write / cfg_index / cfg_data
//
// one pixel beat per cycle unless pix_stall; the line store is read at accept and
// written back from stage a, one read and one write port on the same 48-bit
// entry; a result passes stages a and c and the output register after the beat
// that completes its window; the frame needs width+1 flush beats at its end
// reset is synchronous; the line store has no clear, its stale rows only feed
// masked border taps; a stall on mag holds the pipeline, pix stalls once it fills
module sobel_edge_magnitude_rgb_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_stall,
  input  sobm_pkg::pix_beat_t                 pix,
  output logic                                mag_valid,
  input  logic                                mag_stall,
  output sobm_pkg::mag_beat_t                 mag,
  input  logic                                cfg_write,
  input  sobm_pkg::cfg_reg_t                  cfg_index,
  input  logic [sobm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import sobm_pkg::*;

  `include "sobel_edge_magnitude_rgb_top_defines.svh"

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = ((AW > WIDTH_BITS) ? AW : WIDTH_BITS) + 1;
  localparam int RW = HEIGHT_BITS + 1;

  // configuration and position
  logic [WIDTH_BITS-1:0]  width;
  logic [HEIGHT_BITS-1:0] height;
  logic [AW-1:0]          col;
  logic [HEIGHT_BITS-1:0] row;

  // pipeline control
  logic pix_acc, a_valid, a_adv, c_valid, c_move, c_free, out_free;

  // accept-time signals
  logic [CW-1:0]          width_ext, col_ext, c_inc, cc;
  logic [AW-1:0]          c_eff, col_next;
  logic [RW-1:0]          row_ext, height_ext, cr;
  logic [HEIGHT_BITS-1:0] row_next;
  logic                   c_wrap;
  logic [PIX_BITS-1:0]    pix_word;
  item_ctl_t              ctl;

  // stage a
  logic [AW-1:0]       a_col;
  logic [PIX_BITS-1:0] a_pix;
  item_ctl_t           a_ctl;

  // line store and window
  logic [STORE_BITS-1:0] rd_data;
  logic [PIX_BITS-1:0]   top, mid;
  logic [PIX_BITS-1:0]   win [6];
  logic [PIX_BITS-1:0]   ow  [9];
  logic [PIX_BITS-1:0]   ow_c [9];
  logic                  c_end;

  // output
  chan_win_t  win_r, win_g, win_b;
  logic [7:0] mag_r, mag_g, mag_b;

  // handshakes
  assign out_free  = !mag_valid || !mag_stall;
  assign c_free    = !c_valid || out_free;
  assign c_move    = c_valid && out_free;
  assign a_adv     = a_valid && c_free;
  assign pix_stall = a_valid && !c_free;
  assign pix_acc   = pix_valid && !pix_stall;

  // position of this beat
  assign width_ext  = CW'(width);
  assign col_ext    = CW'(col);
  assign row_ext    = RW'(row);
  assign height_ext = RW'(height);
  assign c_eff      = (col_ext >= width_ext) ? '0 : col;
  assign pix_word   = (!pix.flush_item && (row < height)) ?
                      {pix.red_in, pix.green_in, pix.blue_in} : '0;

  // result position and border flags
  always_comb begin
    ctl        = '0;
    ctl.c_zero = (c_eff == '0);
    if (ctl.c_zero) begin
      cr            = row_ext - RW'(2);
      cc            = width_ext - CW'(1);
      ctl.res_valid = (row_ext >= RW'(2));
    end else begin
      cr            = row_ext - RW'(1);
      cc            = CW'(c_eff) - CW'(1);
      ctl.res_valid = (row_ext >= RW'(1));
    end
    ctl.res_valid = ctl.res_valid && (cr < height_ext);
    ctl.top_m     = (cr == '0);
    ctl.bot_m     = (cr == height_ext - RW'(1));
    ctl.left_m    = (cc == '0);
    ctl.right_m   = (cc == width_ext - CW'(1));
    ctl.frame_end = ctl.res_valid && ctl.bot_m && ctl.right_m;
    c_inc         = CW'(c_eff) + CW'(1);
    c_wrap        = (c_inc >= width_ext);
    col_next      = c_wrap ? '0 : c_inc[AW-1:0];
    row_next      = c_wrap ? (row + HEIGHT_BITS'(1)) : row;
    ctl.restart   = ctl.frame_end ||
                    (!ctl.res_valid && (RW'(row_next) > height_ext + RW'(1)));
  end

  // configuration and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WIDTH_BITS'(WIDTH_RESET);
      height <= HEIGHT_BITS'(HEIGHT_RESET);
      col    <= '0;
      row    <= '0;
    end else if (cfg_write) begin
      col <= '0;
      row <= '0;
      case (cfg_index)
        REG_WIDTH: begin
          if (cfg_data[WIDTH_BITS-1:0] < WIDTH_BITS'(WIDTH_MIN)) begin
            width <= WIDTH_BITS'(WIDTH_MIN);
          end else if (CW'(cfg_data[WIDTH_BITS-1:0]) > CW'(MAX_WIDTH)) begin
            width <= WIDTH_BITS'(MAX_WIDTH);
          end else begin
            width <= cfg_data[WIDTH_BITS-1:0];
          end
        end
        REG_HEIGHT: begin
          if (cfg_data[HEIGHT_BITS-1:0] < HEIGHT_BITS'(HEIGHT_MIN)) begin
            height <= HEIGHT_BITS'(HEIGHT_MIN);
          end else if (cfg_data[HEIGHT_BITS-1:0] > HEIGHT_BITS'(HEIGHT_MAX)) begin
            height <= HEIGHT_BITS'(HEIGHT_MAX);
          end else begin
            height <= cfg_data[HEIGHT_BITS-1:0];
          end
        end
        default: begin
        end
      endcase
    end else if (pix_acc) begin
      col <= ctl.restart ? '0 : col_next;
      row <= ctl.restart ? '0 : row_next;
    end
  end

  // stage a: beat waits for its line store entry
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pix_acc) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      a_col <= c_eff;
      a_pix <= pix_word;
      a_ctl <= ctl;
    end
  end

  // two line rows per entry: upper half newest, lower half the row before
  sobm_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (pix_acc),
    .rd_addr (c_eff),
    .rd_data (rd_data),
    .wr_en   (a_adv),
    .wr_addr (a_col),
    .wr_data ({a_pix, mid})
  );

  assign mid = rd_data[STORE_BITS-1:PIX_BITS];
  assign top = rd_data[PIX_BITS-1:0];

  // window taps with the border masks applied
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ow[k] = win[k];
    end
    ow[6] = a_ctl.c_zero ? '0 : top;
    ow[7] = a_ctl.c_zero ? '0 : mid;
    ow[8] = a_ctl.c_zero ? '0 : a_pix;
    if (a_ctl.top_m) begin
      ow[0] = '0;
      ow[3] = '0;
      ow[6] = '0;
    end
    if (a_ctl.bot_m) begin
      ow[2] = '0;
      ow[5] = '0;
      ow[8] = '0;
    end
    if (a_ctl.left_m) begin
      ow[0] = '0;
      ow[1] = '0;
      ow[2] = '0;
    end
    if (a_ctl.right_m) begin
      ow[6] = '0;
      ow[7] = '0;
      ow[8] = '0;
    end
  end

  // window shift, old taps dropped at row start; cleared on rst, cfg_write, restart
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      for (int k = 0; k < 6; k++) begin
        win[k] <= '0;
      end
    end else if (a_adv) begin
      if (a_ctl.restart) begin
        for (int k = 0; k < 6; k++) begin
          win[k] <= '0;
        end
      end else begin
        win[0] <= a_ctl.c_zero ? '0 : win[3];
        win[1] <= a_ctl.c_zero ? '0 : win[4];
        win[2] <= a_ctl.c_zero ? '0 : win[5];
        win[3] <= top;
        win[4] <= mid;
        win[5] <= a_pix;
      end
    end
  end

  // stage c: masked window of one result
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (a_adv) begin
      c_valid <= a_ctl.res_valid;
    end else if (c_move) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      for (int k = 0; k < 9; k++) begin
        ow_c[k] <= ow[k];
      end
      c_end <= a_ctl.frame_end;
    end
  end

  // per-channel magnitude
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      win_r[k] = ow_c[k][23:16];
      win_g[k] = ow_c[k][15:8];
      win_b[k] = ow_c[k][7:0];
    end
  end

  sobm_channel_edge u_red   (.win (win_r), .mag (mag_r));
  sobm_channel_edge u_green (.win (win_g), .mag (mag_g));
  sobm_channel_edge u_blue  (.win (win_b), .mag (mag_b));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (c_move) begin
      mag_valid <= 1'b1;
    end else if (!mag_stall) begin
      mag_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_move) begin
      mag.red_edge   <= mag_r;
      mag.green_edge <= mag_g;
      mag.blue_edge  <= mag_b;
      mag.frame_end  <= c_end;
    end
  end

  // checks; a frame restart sends the next beat back to column zero, whose
  // stale read only reaches masked taps
  `SOBM_ALWAYS(col_bound_a, col_ext < width_ext, "column count reached the row width")
  `SOBM_ALWAYS(row_bound_a, row_ext <= height_ext + RW'(1), "row count ran past the flush row")
  `SOBM_IMPLY(store_hazard_a, pix_acc && a_adv && !a_ctl.restart, c_eff != a_col, "store hazard")
  `SOBM_NEXT(c_hold_a, c_valid && !out_free, c_valid, "stalled result lost in stage c")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

import sobm_pkg::*;

// widest row the line stores hold
localparam int LINE_MAX = 2048;

// sobel kernels, index row*3+col
localparam int SOBEL_GX [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
localparam int SOBEL_GY [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

// predicts the edge magnitudes of the pixel stream and checks them in order
class edge_tracker;
  int unsigned width_px;
  int unsigned height_rows;
  bit [23:0] line_prev [LINE_MAX];
  bit [23:0] line_older [LINE_MAX];
  // window, index col*3+row, col 0 left, row 0 top
  bit [23:0] win [9];
  int unsigned col;
  int unsigned row;
  mag_beat_t pending_mags [$];
  int unsigned errors;
  int unsigned results_checked;
  int unsigned frames_done;

  function new();
    width_px = WIDTH_RESET;
    height_rows = HEIGHT_RESET;
    foreach (line_prev[i]) begin
      line_prev[i] = '0;
      line_older[i] = '0;
    end
    errors = 0;
    results_checked = 0;
    frames_done = 0;
    restart();
  endfunction

  function void restart();
    col = 0;
    row = 0;
    foreach (win[k]) win[k] = '0;
  endfunction

  // register write, saturated to the legal range, restarts the frame
  function void set_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
    int unsigned v;
    if (idx == REG_WIDTH) begin
      v = 32'(data[WIDTH_BITS-1:0]);
      if (v < WIDTH_MIN) v = WIDTH_MIN;
      if (v > LINE_MAX) v = LINE_MAX;
      width_px = v;
    end else begin
      v = 32'(data);
      if (v < HEIGHT_MIN) v = HEIGHT_MIN;
      if (v > HEIGHT_MAX) v = HEIGHT_MAX;
      height_rows = v;
    end
    restart();
  endfunction

  // (|gx| + |gy|) / 2 for one channel, saturated
  function bit [7:0] chan_mag(bit [23:0] t [9], int unsigned sh);
    int gx;
    int gy;
    int v;
    int k;
    gx = 0;
    gy = 0;
    for (k = 0; k < 9; k++) begin
      v = int'((t[(k % 3) * 3 + k / 3] >> sh) & 24'hFF);
      gx += SOBEL_GX[k] * v;
      gy += SOBEL_GY[k] * v;
    end
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    v = (gx + gy) >> 1;
    return (v > 255) ? MAG_MAX : v[7:0];
  endfunction

  // accepted pixel beat: advance the window and queue any finished result
  function void note_pixel(pix_beat_t b);
    bit [23:0] px;
    bit [23:0] top;
    bit [23:0] mid;
    bit [23:0] tap [9];
    int unsigned c;
    int unsigned r;
    int unsigned cr;
    int unsigned cc;
    int k;
    bit hit;
    mag_beat_t m;
    c = col;
    r = row;
    px = '0;
    cr = 0;
    cc = 0;
    if (c >= width_px) c = 0;
    if (!b.flush_item && r < height_rows) px = {b.red_in, b.green_in, b.blue_in};

    // line stores shift down one row at this column
    top = line_older[c];
    mid = line_prev[c];
    line_older[c] = mid;
    line_prev[c] = px;

    if (c == 0) begin
      // close out the last pixel of the previous row
      for (k = 0; k < 6; k++) tap[k] = win[k + 3];
      tap[6] = '0;
      tap[7] = '0;
      tap[8] = '0;
      foreach (win[i]) win[i] = '0;
      hit = (r >= 2);
      if (hit) begin
        cr = r - 2;
        cc = width_px - 1;
      end
    end else begin
      for (k = 0; k < 6; k++) win[k] = win[k + 3];
      hit = (r >= 1);
      if (hit) begin
        cr = r - 1;
        cc = c - 1;
      end
    end
    win[6] = top;
    win[7] = mid;
    win[8] = px;
    if (c != 0) tap = win;
    if (hit && cr >= height_rows) hit = 1'b0;

    c++;
    if (c >= width_px) begin
      c = 0;
      r++;
    end
    col = c;
    row = r;

    if (!hit) begin
      if (row > height_rows + 1) restart();
      return;
    end

    // neighbors outside the image are zero
    if (cr == 0) begin
      tap[0] = '0;
      tap[3] = '0;
      tap[6] = '0;
    end
    if (cr == height_rows - 1) begin
      tap[2] = '0;
      tap[5] = '0;
      tap[8] = '0;
    end
    if (cc == 0) begin
      tap[0] = '0;
      tap[1] = '0;
      tap[2] = '0;
    end
    if (cc == width_px - 1) begin
      tap[6] = '0;
      tap[7] = '0;
      tap[8] = '0;
    end

    m.red_edge = chan_mag(tap, 16);
    m.green_edge = chan_mag(tap, 8);
    m.blue_edge = chan_mag(tap, 0);
    m.frame_end = (cr == height_rows - 1 && cc == width_px - 1);
    pending_mags.push_back(m);
    if (m.frame_end) begin
      frames_done++;
      restart();
    end
  endfunction

  function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // accepted result beat against the oldest prediction
  function void check_mag(mag_beat_t got);
    mag_beat_t want;
    if (pending_mags.size() == 0) begin
      $error("edge result with nothing pending: red %0d green %0d blue %0d end %0d",
             got.red_edge, got.green_edge, got.blue_edge, got.frame_end);
      errors++;
      return;
    end
    want = pending_mags.pop_front();
    results_checked++;
    cmp_field("red_edge", want.red_edge, got.red_edge);
    cmp_field("green_edge", want.green_edge, got.green_edge);
    cmp_field("blue_edge", want.blue_edge, got.blue_edge);
    cmp_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
  endfunction
endclass

module tb_top;

  localparam int unsigned RANDOM_BEATS = 560;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // hand-picked beats {rgb, flush}: two 3x2 frames back to back, then a 3x1 frame
  localparam bit [24:0] HAND_BEATS [27] = '{
    {24'hFF00FF, 1'b0}, {24'h00FF00, 1'b0}, {24'hFFFFFF, 1'b0},
    {24'h000000, 1'b0}, {24'h123456, 1'b1}, {24'h0000FF, 1'b0},
    {24'h000000, 1'b1}, {24'hFFFFFF, 1'b0}, {24'hA5A5A5, 1'b1}, {24'h5A5A5A, 1'b0},
    {24'hFFFFFF, 1'b0}, {24'hFFFFFF, 1'b0}, {24'hFFFFFF, 1'b0},
    {24'h000000, 1'b0}, {24'hFFFFFF, 1'b0}, {24'h000000, 1'b0},
    {24'hFFFFFF, 1'b1}, {24'hFFFFFF, 1'b1}, {24'h000000, 1'b1}, {24'hFFFFFF, 1'b0},
    {24'hFFFFFF, 1'b0}, {24'h000000, 1'b0}, {24'hFFFFFF, 1'b0},
    {24'h808080, 1'b1}, {24'h7F7F7F, 1'b0}, {24'hFFFFFF, 1'b1}, {24'h000000, 1'b1}
  };

  logic clk;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  pix_beat_t pix = '0;
  logic mag_valid;
  logic mag_stall = 1'b0;
  mag_beat_t mag;
  logic cfg_write = 1'b0;
  cfg_reg_t cfg_index = REG_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  edge_tracker tracker = new();

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  bit quiet = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned settings_written = 0;
  int unsigned cycles = 0;

  sobel_edge_magnitude_rgb_top #(
    .MAX_WIDTH(LINE_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix(pix),
    .mag_valid(mag_valid),
    .mag_stall(mag_stall),
    .mag(mag),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    mag_stall <= !quiet && ($urandom_range(99) < sink_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && mag_valid && !mag_stall) tracker.check_mag(mag);
  end

  // one pixel beat; called and returns just after a falling edge
  task automatic push_pixel(input pix_beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix <= b;
    pix_valid <= 1'b1;
    do @(posedge clk); while (pix_stall);
    tracker.note_pixel(b);
    beats_sent++;
    @(negedge clk);
  endtask

  // both size registers, block idle
  task automatic program_regs(input logic [CFG_DATA_BITS-1:0] wd,
                              input logic [CFG_DATA_BITS-1:0] hd);
    cfg_write <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= wd;
    @(posedge clk);
    tracker.set_reg(REG_WIDTH, wd);
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= hd;
    @(posedge clk);
    tracker.set_reg(REG_HEIGHT, hd);
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_written++;
  endtask

  // drop valid, wait for every predicted result, then let the pipe empty
  task automatic settle();
    pix_valid <= 1'b0;
    while (tracker.pending_mags.size() != 0) @(negedge clk);
    @(posedge clk);
    quiet = 1'b1;
    repeat (DRAIN_CYCLES) @(negedge clk);
    @(posedge clk);
    quiet = 1'b0;
    @(negedge clk);
  endtask

  // one frame plus its flush tail, random content, optionally cut short
  task automatic send_frame(input int unsigned cut);
    int unsigned body;
    int unsigned total;
    int unsigned n;
    pix_beat_t b;
    body = tracker.width_px * tracker.height_rows;
    total = body + tracker.width_px + 1;
    if (cut != 0 && cut < total) total = cut;
    for (n = 0; n < total; n++) begin
      b = pix_beat_t'(25'($urandom));
      if (n < body) b.flush_item = ($urandom_range(15) == 0);
      else b.flush_item = ($urandom_range(3) != 0);
      push_pixel(b);
    end
  endtask

  initial begin
    int unsigned i;
    int unsigned f;
    int unsigned nf;
    int unsigned start;
    int unsigned done;
    logic [CFG_DATA_BITS-1:0] wd;
    logic [CFG_DATA_BITS-1:0] hd;

    // synchronous reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: narrowest rows, flush inside and after the frame, back to back frames
    src_idle_pct = 11;
    sink_stall_pct = 70;
    program_regs(13'h1000, 13'd2);
    for (i = 0; i < 27; i++) begin
      if (i == 20) begin
        settle();
        program_regs(13'd1, 13'd0);
      end
      push_pixel(pix_beat_t'(HAND_BEATS[i]));
    end
    settle();

    // random phases, mostly whole frames of small size
    start = beats_sent;
    done = 0;
    while (done < RANDOM_BEATS) begin
      if (done < RANDOM_BEATS / 3) begin
        src_idle_pct = 11;
        sink_stall_pct = 70;
      end else if (done < 2 * RANDOM_BEATS / 3) begin
        src_idle_pct = 70;
        sink_stall_pct = 11;
      end else begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      if ($urandom_range(7) == 0) begin
        // arbitrary register values, a short burst
        wd = CFG_DATA_BITS'($urandom);
        hd = CFG_DATA_BITS'($urandom);
        program_regs(wd, hd);
        send_frame($urandom_range(5, 40));
      end else begin
        wd = CFG_DATA_BITS'(($urandom_range(4) == 0) ? $urandom_range(0, 40) :
                                                       $urandom_range(3, 12));
        hd = CFG_DATA_BITS'($urandom_range(0, 6));
        program_regs(wd, hd);
        nf = $urandom_range(1, 3);
        for (f = 0; f < nf; f++) begin
          if (f == nf - 1 && $urandom_range(5) == 0) send_frame($urandom_range(1, 60));
          else send_frame(0);
        end
      end
      settle();
      done = beats_sent - start;
    end

    // widest rows and tallest frame, a short burst into the first row
    src_idle_pct = 0;
    sink_stall_pct = 0;
    program_regs(13'd4095, 13'h1FFF);
    send_frame(48);
    settle();

    $display("sent %0d pixel beats over %0d register settings", beats_sent, settings_written);
    $display("checked %0d edge results, %0d frames completed",
             tracker.results_checked, tracker.frames_done);
    if (tracker.errors == 0 && tracker.pending_mags.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
